/* src/irpwfe_pkg.sv */
// Shared types and constants for the infrared pulse-width frame encoder.
// Used by irpwfe_seq and ir_pulse_width_frame_encoder_top; depends on nothing.

package irpwfe_pkg;

    // Widths fixed by the item and register fields.
    localparam int unsigned DataWidth   = 8;
    localparam int unsigned CountWidth  = 24;
    localparam int unsigned PulseWidth  = 8;
    localparam int unsigned CfgIdxWidth = 2;

    // Register values after reset.
    localparam logic [PulseWidth-1:0] PreamblePulsesRst = 8'd5;
    localparam logic [CountWidth-1:0] PreambleTicksRst  = 24'd150000;
    localparam logic [CountWidth-1:0] ShortTicksRst     = 24'd70000;
    localparam logic [CountWidth-1:0] LongTicksRst      = 24'd280000;

    // Largest data value that is sent as it stands.
    localparam logic [DataWidth-1:0] DataMax = 8'd3;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0]
    {
        CFG_PREAMBLE_PULSES = 2'd0,
        CFG_PREAMBLE_TICKS  = 2'd1,
        CFG_SHORT_TICKS     = 2'd2,
        CFG_LONG_TICKS      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        PH_IDLE    = 3'd0,
        PH_PRE_ON  = 3'd1,
        PH_PRE_OFF = 3'd2,
        PH_BIT_ON  = 3'd3,
        PH_BIT_OFF = 3'd4
    } phase_t;

    typedef struct packed
    {
        logic [PulseWidth-1:0] preamble_pulses;
        logic [CountWidth-1:0] preamble_ticks;
        logic [CountWidth-1:0] short_ticks;
        logic [CountWidth-1:0] long_ticks;
    } cfg_t;

    typedef struct packed
    {
        logic carrier_on;
        logic busy_res;
        logic frame_done;
    } res_t;

endpackage

/* src/ir_pulse_width_frame_encoder_top.sv */
// Top level of the infrared pulse-width frame encoder: register file,
// result register with skid stage. Depends on irpwfe_pkg and irpwfe_seq.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     op, frame_value
//   result    out_valid / out_stall   carrier_on, busy_res, frame_done
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The sequencer state and the result are worked out in the cycle of acceptance;
// the result is registered, or goes to the skid stage behind a held result.
// Items may therefore be accepted in every cycle while the result side drains.
// Reset is asynchronous and active low; it returns the sequencer to idle and
// loads the registers with their default values. The register port is always ready.
// A stall on the result side is absorbed by a one-entry skid stage; in_stall
// rises only once that stage is full, and it comes straight from a flip-flop.

module ir_pulse_width_frame_encoder_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   op,
    input  logic [irpwfe_pkg::DataWidth-1:0]       frame_value,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   carrier_on,
    output logic                                   busy_res,
    output logic                                   frame_done,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [irpwfe_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [irpwfe_pkg::CountWidth-1:0]      cfg_data
);

    irpwfe_pkg::cfg_t   cfg_reg;
    irpwfe_pkg::res_t   seq_res;
    irpwfe_pkg::res_t   out_res_reg;
    irpwfe_pkg::res_t   skid_res_reg;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               in_accept;
    logic               out_take;
    logic               out_load;
    logic               skid_load;
    logic               cfg_write;

    // ---------------------------------------------------------------
    // Register file. Writes are only expected while no frame runs.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_pulses <= irpwfe_pkg::PreamblePulsesRst;
            cfg_reg.preamble_ticks  <= irpwfe_pkg::PreambleTicksRst;
            cfg_reg.short_ticks     <= irpwfe_pkg::ShortTicksRst;
            cfg_reg.long_ticks      <= irpwfe_pkg::LongTicksRst;
        end
        else if (cfg_write)
        begin
            case (irpwfe_pkg::cfg_idx_t'(cfg_index))
                irpwfe_pkg::CFG_PREAMBLE_PULSES:
                    cfg_reg.preamble_pulses <= cfg_data[irpwfe_pkg::PulseWidth-1:0];
                irpwfe_pkg::CFG_PREAMBLE_TICKS:
                    cfg_reg.preamble_ticks  <= cfg_data;
                irpwfe_pkg::CFG_SHORT_TICKS:
                    cfg_reg.short_ticks     <= cfg_data;
                irpwfe_pkg::CFG_LONG_TICKS:
                    cfg_reg.long_ticks      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer. It updates its state on the accepted beat and gives
    // the result of that beat combinationally.
    // ---------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    irpwfe_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .op          (irpwfe_pkg::op_t'(op)),
        .frame_value (frame_value),
        .cfg         (cfg_reg),
        .res         (seq_res)
    );

    // ---------------------------------------------------------------
    // Result register and skid stage. The result register is refilled
    // from the skid stage first, so beats leave in order.
    // ---------------------------------------------------------------
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;

        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_load       = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= seq_res;
        end
        else if ((out_take || !out_valid_reg) && skid_valid_reg)
        begin
            out_res_reg <= skid_res_reg;
        end

        if (skid_load)
        begin
            skid_res_reg <= seq_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrier_on = out_res_reg.carrier_on;
    assign busy_res   = out_res_reg.busy_res;
    assign frame_done = out_res_reg.frame_done;

`ifndef SYNTHESIS
    // The skid stage only fills behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while result register empty");

    // A held result is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // Carrier and frame end only occur inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (carrier_on || frame_done)) |-> busy_res)
        else $error("carrier or frame end outside a frame");

    // Frame end comes on a tick with the carrier off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_done) |-> !carrier_on)
        else $error("frame end with carrier on");
`endif

endmodule

/* src/irpwfe_seq.sv */
// Frame sequencer: phase state machine, period counter and bit selection.
// Uses irpwfe_pkg for the phase, op, register and result types.

module irpwfe_seq
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  irpwfe_pkg::op_t                      op,
    input  logic [irpwfe_pkg::DataWidth-1:0]     frame_value,
    input  irpwfe_pkg::cfg_t                     cfg,
    output irpwfe_pkg::res_t                     res
);

    irpwfe_pkg::phase_t                     phase_reg, phase_next;
    logic [irpwfe_pkg::CountWidth-1:0]      period_count_reg, period_count_next;
    logic [irpwfe_pkg::PulseWidth-1:0]      pulses_left_reg, pulses_left_next;
    logic                                   bit_index_reg, bit_index_next;
    logic [1:0]                             frame_bits_reg, frame_bits_next;
    logic [1:0]                             start_bits;
    logic [irpwfe_pkg::PulseWidth-1:0]      pulses_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= irpwfe_pkg::PH_IDLE;
            period_count_reg <= '0;
            pulses_left_reg  <= '0;
            bit_index_reg    <= 1'b0;
            frame_bits_reg   <= 2'b00;
        end
        else
        begin
            phase_reg        <= phase_next;
            period_count_reg <= period_count_next;
            pulses_left_reg  <= pulses_left_next;
            bit_index_reg    <= bit_index_next;
            frame_bits_reg   <= frame_bits_next;
        end
    end

    // Values above the two-bit range are sent as zero.
    assign start_bits = (frame_value > irpwfe_pkg::DataMax) ? 2'b00 : frame_value[1:0];
    assign pulses_dec = pulses_left_reg - 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        period_count_next = period_count_reg;
        pulses_left_next  = pulses_left_reg;
        bit_index_next    = bit_index_reg;
        frame_bits_next   = frame_bits_reg;
        res               = '0;

        if (accept)
        begin
            if (op == irpwfe_pkg::OP_START)
            begin
                res.busy_res = 1'b1;
                if (phase_reg == irpwfe_pkg::PH_IDLE)
                begin
                    frame_bits_next = start_bits;
                    bit_index_next  = 1'b0;
                    if (cfg.preamble_pulses != '0)
                    begin
                        phase_next        = irpwfe_pkg::PH_PRE_ON;
                        pulses_left_next  = cfg.preamble_pulses;
                        period_count_next = cfg.preamble_ticks;
                    end
                    else
                    begin
                        pulses_left_next  = '0;
                        phase_next        = irpwfe_pkg::PH_BIT_ON;
                        period_count_next = start_bits[1] ? cfg.long_ticks : cfg.short_ticks;
                    end
                end
            end
            else if (phase_reg != irpwfe_pkg::PH_IDLE)
            begin
                res.busy_res   = 1'b1;
                res.carrier_on = (phase_reg == irpwfe_pkg::PH_PRE_ON) ||
                                 (phase_reg == irpwfe_pkg::PH_BIT_ON);
                if (period_count_reg > 24'd1)
                begin
                    period_count_next = period_count_reg - 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        irpwfe_pkg::PH_PRE_ON:
                        begin
                            phase_next        = irpwfe_pkg::PH_PRE_OFF;
                            period_count_next = cfg.preamble_ticks;
                        end
                        irpwfe_pkg::PH_PRE_OFF:
                        begin
                            pulses_left_next = pulses_dec;
                            if (pulses_dec != '0)
                            begin
                                phase_next        = irpwfe_pkg::PH_PRE_ON;
                                period_count_next = cfg.preamble_ticks;
                            end
                            else
                            begin
                                // Bit index is still zero here: the high bit goes first.
                                phase_next        = irpwfe_pkg::PH_BIT_ON;
                                period_count_next = frame_bits_reg[1] ? cfg.long_ticks
                                                                      : cfg.short_ticks;
                            end
                        end
                        irpwfe_pkg::PH_BIT_ON:
                        begin
                            phase_next        = irpwfe_pkg::PH_BIT_OFF;
                            period_count_next =
                                frame_bits_reg[~bit_index_reg] ? cfg.short_ticks
                                                               : cfg.long_ticks;
                        end
                        default:
                        begin
                            if (!bit_index_reg)
                            begin
                                bit_index_next    = 1'b1;
                                phase_next        = irpwfe_pkg::PH_BIT_ON;
                                period_count_next = frame_bits_reg[0] ? cfg.long_ticks
                                                                      : cfg.short_ticks;
                            end
                            else
                            begin
                                phase_next        = irpwfe_pkg::PH_IDLE;
                                period_count_next = '0;
                                bit_index_next    = 1'b0;
                                res.frame_done    = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

endmodule
